// ===== src/rcpwm_pkg.sv =====
// shared types and constants for the rc pwm receiver decoder
// no dependencies; imported by every module of the block
`default_nettype none

package rcpwm_pkg;

	// channel roles
	localparam int CH_X        = 0;
	localparam int CH_Y        = 1;
	localparam int CH_SPEED    = 2;
	localparam int CH_SWITCH   = 4;
	localparam int CH_RESET    = 4;
	localparam int CH_OVERRIDE = 6;
	localparam int CH_MONITOR  = 8;

	// field and port widths
	localparam int CHAN_W     = 4;
	localparam int STAMP_W    = 32;
	localparam int MASK_W     = 10;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 144;
	localparam int RES_W      = 138;

	typedef enum logic [1:0] {
		LS_NOT_STARTED  = 2'd0,
		LS_NOT_VALID    = 2'd1,
		LS_VALID        = 2'd2,
		LS_DISCONNECTED = 2'd3
	} link_t;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SPEED_GAIN   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_VALID_MIN    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_VALID_MAX    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DISCONNECT   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SWITCH_LIMIT = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_RESET_ARM    = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_WIDE_MASK    = 3'd6;

	// register reset values
	localparam logic [15:0]       RST_SPEED_GAIN   = 16'd256;
	localparam logic [15:0]       RST_VALID_MIN    = 16'd490;
	localparam logic [15:0]       RST_VALID_MAX    = 16'd1050;
	localparam logic [31:0]       RST_DISCONNECT   = 32'd20000;
	localparam logic [31:0]       RST_SWITCH_LIMIT = 32'd20000;
	localparam logic [15:0]       RST_RESET_ARM    = 16'd530;
	localparam logic [MASK_W-1:0] RST_WIDE_MASK    = 10'd15;

	// arithmetic constants
	localparam logic [31:0] STICK_CENTER  = 32'd750;
	localparam logic [31:0] SPEED_ZERO    = 32'd500;
	localparam logic [31:0] SCALE_SAT_MAG = 32'd16384000;  // 2^31 * 125 / 16384
	localparam logic [20:0] SCALE_MULT    = 21'd2048000;   // 16384 * 125
	localparam logic [60:0] SAT_LIMIT     = 61'd33554432000000; // 2^31 * 15625
	localparam int          DIVISOR       = 15625;

	// radix-16 divider by the constant
	localparam int LANES      = 3;
	localparam int LANE_LIN   = 0;
	localparam int LANE_ANG   = 1;
	localparam int LANE_SPD   = 2;
	localparam int DIV_W      = 48;
	localparam int DIGIT_W    = 4;
	localparam int DIV_DIGITS = DIV_W / DIGIT_W;
	localparam int DCNT_W     = 4;
	localparam int REM_W      = 14;
	localparam int PREM_W     = REM_W + DIGIT_W;
	localparam int QUO_W      = 31;

	typedef struct packed {
		logic accept;
		logic cap;
		logic link;
		logic mul1;
		logic mul2;
		logic divld;
		logic dstep;
		logic ev_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

	// result item, last field (out_channel) in the low bits
	typedef struct packed {
		logic               reset_request;
		logic               override_on;
		logic               auto_mode;
		logic signed [31:0] speed_scale;
		logic signed [31:0] angular_velocity;
		logic signed [31:0] linear_velocity;
		link_t              link_state;
		logic               width_updated;
		logic [31:0]        pulse_width;
		logic [CHAN_W-1:0]  out_channel;
	} res_t;

	// digit times divisor
	function automatic logic [PREM_W-1:0] div_multiple(input logic [DIGIT_W-1:0] d);
		logic [PREM_W-1:0] m;
		m = PREM_W'(d) * PREM_W'(DIVISOR);
		return m;
	endfunction

	// signed Q16.16 result with saturation
	function automatic logic signed [31:0] sat_result(input logic sat, input logic neg,
			input logic [QUO_W-1:0] q);
		logic [31:0] mag;
		logic [31:0] r;
		mag = {1'b0, q};
		if (sat) begin
			r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (neg) begin
			r = 32'd0 - mag;
		end else begin
			r = mag;
		end
		return $signed(r);
	endfunction

endpackage

`default_nettype wire

// ===== src/rcpwm_div.sv =====
// radix-16 divider by a constant, one digit per step, three lanes in parallel
// depends on rcpwm_pkg
`default_nettype none

module rcpwm_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic                        step,
	input  wire logic [rcpwm_pkg::DIV_W-1:0] dividend [rcpwm_pkg::LANES],
	output logic      [rcpwm_pkg::QUO_W-1:0] quotient [rcpwm_pkg::LANES],
	output logic                             done
);
	import rcpwm_pkg::*;

	logic [DIV_W-1:0]   num_q  [LANES];
	logic [REM_W-1:0]   rem_q  [LANES];
	logic [PREM_W-1:0]  prem   [LANES];
	logic [DIGIT_W-1:0] dig    [LANES];
	logic [REM_W-1:0]   rem_nx [LANES];
	logic [DCNT_W-1:0]  cnt_q;
	logic               adv;

	assign done = (cnt_q == '0);
	assign adv  = step && !done;

	// partial remainder and quotient digit
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prem[l] = {rem_q[l], num_q[l][DIV_W-1 -: DIGIT_W]};
			dig[l]  = '0;
			for (int k = 1; k < (1 << DIGIT_W); k++) begin
				if (prem[l] >= div_multiple(DIGIT_W'(k))) begin
					dig[l] = DIGIT_W'(k);
				end
			end
			rem_nx[l] = REM_W'(prem[l] - div_multiple(dig[l]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= '0;
			end
		end else if (load) begin
			cnt_q <= DCNT_W'(DIV_DIGITS);
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= '0;
			end
		end else if (adv) begin
			cnt_q <= cnt_q - 1'b1;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= rem_nx[l];
			end
		end
	end

	// dividend shifts out the top while quotient digits shift in at the bottom
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (load) begin
				num_q[l] <= dividend[l];
			end else if (adv) begin
				num_q[l] <= {num_q[l][DIV_W-DIGIT_W-1:0], dig[l]};
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quotient[l] = num_q[l][QUO_W-1:0];
		end
	end

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cnt_q == DCNT_W'(DIV_DIGITS)))
		else $error("digit count not set by load");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!load && adv) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("digit count did not advance");

	for (genvar l = 0; l < LANES; l++) begin : g_rem_chk
		a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
			rem_q[l] < REM_W'(DIVISOR))
			else $error("partial remainder out of range");
	end

endmodule

`default_nettype wire

// ===== src/rcpwm_datapath.sv =====
// datapath: channel stores, config registers, link logic, multipliers, result register
// depends on rcpwm_pkg and rcpwm_div
`default_nettype none

module rcpwm_datapath #(
	parameter int CHANNELS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire rcpwm_pkg::cmd_t                  cmd,
	output rcpwm_pkg::status_t                    status,
	input  wire logic                             cfg_we,
	input  wire logic [rcpwm_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [rcpwm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [rcpwm_pkg::CHAN_W-1:0]     in_channel,
	input  wire logic                             in_level,
	input  wire logic [rcpwm_pkg::STAMP_W-1:0]    in_stamp,
	output rcpwm_pkg::res_t                       res
);
	import rcpwm_pkg::*;

	localparam int CH_W = $clog2(CHANNELS);

	// config registers
	logic [15:0]       gain_q;
	logic [15:0]       vmin_q;
	logic [15:0]       vmax_q;
	logic [31:0]       disc_q;
	logic [31:0]       swl_q;
	logic [15:0]       arm_lim_q;
	logic [MASK_W-1:0] wmask_q;

	link_t link_q;
	link_t link_nx;
	logic  armed_q;
	logic  armed_nx;

	logic [CHAN_W-1:0]  in_ch_q;
	logic               in_lvl_q;
	logic [STAMP_W-1:0] in_stamp_q;

	logic [31:0] rise_q  [CHANNELS];
	logic [31:0] width_q [CHANNELS];

	logic [31:0] w_x, w_y, w_s, w_rst, w_ovr, w_mon;

	// capture
	logic              ch_ok;
	logic [CH_W-1:0]   ch_idx;
	logic [MASK_W-1:0] mask_sh;
	logic [31:0]       diff;
	logic              upd;

	// evaluate
	logic any_nz;
	logic sticks_ok;
	logic [31:0] mag_y_s1, mag_x_s1, mag_s_s1;
	logic neg_lin_s1, neg_ang_s1, neg_spd_s1, auto_s1, ovr_s1, rreq_s1;
	logic [63:0] p_lin_s2, p_ang_s2;
	logic [44:0] spd_n_s2, spd_n_s3;
	logic        spd_sat_s2, spd_sat_s3;
	logic [55:0] m_lin_s3, m_ang_s3;
	logic        big_lin_s3, big_ang_s3;
	logic [60:0] n_lin, n_ang;
	logic [LANES-1:0] sat_s4;

	logic [DIV_W-1:0] div_in [LANES];
	logic [QUO_W-1:0] quo    [LANES];
	logic             div_done;

	res_t res_q;

	// role widths, override and monitor roles beyond the channel count read as zero
	assign w_x   = width_q[CH_X];
	assign w_y   = width_q[CH_Y];
	assign w_s   = width_q[CH_SPEED];
	assign w_rst = width_q[CH_RESET];

	if (CH_OVERRIDE < CHANNELS) begin : g_ovr
		assign w_ovr = width_q[CH_OVERRIDE];
	end else begin : g_ovr_none
		assign w_ovr = '0;
	end

	if (CH_MONITOR < CHANNELS) begin : g_mon
		assign w_mon = width_q[CH_MONITOR];
	end else begin : g_mon_none
		assign w_mon = '0;
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= RST_SPEED_GAIN;
			vmin_q    <= RST_VALID_MIN;
			vmax_q    <= RST_VALID_MAX;
			disc_q    <= RST_DISCONNECT;
			swl_q     <= RST_SWITCH_LIMIT;
			arm_lim_q <= RST_RESET_ARM;
			wmask_q   <= RST_WIDE_MASK;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SPEED_GAIN:   gain_q    <= cfg_data[15:0];
				REG_VALID_MIN:    vmin_q    <= cfg_data[15:0];
				REG_VALID_MAX:    vmax_q    <= cfg_data[15:0];
				REG_DISCONNECT:   disc_q    <= cfg_data;
				REG_SWITCH_LIMIT: swl_q     <= cfg_data;
				REG_RESET_ARM:    arm_lim_q <= cfg_data[15:0];
				REG_WIDE_MASK:    wmask_q   <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// input item register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_ch_q    <= in_channel;
			in_lvl_q   <= in_level;
			in_stamp_q <= in_stamp;
		end
	end

	// capture edge: modular difference at the channel's counter width
	assign ch_ok   = {1'b0, in_ch_q} < (CHAN_W + 1)'(CHANNELS);
	assign ch_idx  = in_ch_q[CH_W-1:0];
	assign mask_sh = wmask_q >> in_ch_q;

	always_comb begin
		diff = in_stamp_q - rise_q[ch_idx];
		if (!mask_sh[0]) begin
			diff[31:16] = '0;
		end
	end

	assign upd = ch_ok && !in_lvl_q && (diff != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				rise_q[c]  <= '0;
				width_q[c] <= '0;
			end
		end else if (cmd.cap && ch_ok) begin
			if (in_lvl_q) begin
				rise_q[ch_idx] <= in_stamp_q;
			end else if (upd) begin
				width_q[ch_idx] <= diff;
			end
		end
	end

	// link state step
	always_comb begin
		any_nz = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			any_nz = any_nz | (|width_q[c]);
		end
	end

	assign sticks_ok = (w_x > {16'd0, vmin_q}) && (w_x < {16'd0, vmax_q}) &&
		(w_y > {16'd0, vmin_q}) && (w_y < {16'd0, vmax_q}) &&
		(w_s > {16'd0, vmin_q}) && (w_s < {16'd0, vmax_q});

	always_comb begin
		case (link_q)
			LS_NOT_STARTED: link_nx = any_nz ? LS_NOT_VALID : LS_NOT_STARTED;
			default: begin
				if (w_mon > disc_q) begin
					link_nx = LS_DISCONNECTED;
				end else if (sticks_ok) begin
					link_nx = LS_VALID;
				end else begin
					link_nx = LS_NOT_VALID;
				end
			end
		endcase
	end

	assign armed_nx = armed_q || (w_rst > {16'd0, arm_lim_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q  <= LS_NOT_STARTED;
			armed_q <= 1'b0;
		end else if (cmd.link) begin
			link_q  <= link_nx;
			armed_q <= armed_nx;
		end
	end

	// evaluate pipeline, each stage enabled by its command
	always_ff @(posedge clk) begin
		if (cmd.link) begin
			mag_y_s1   <= (w_y >= STICK_CENTER) ? w_y - STICK_CENTER : STICK_CENTER - w_y;
			mag_x_s1   <= (w_x >= STICK_CENTER) ? w_x - STICK_CENTER : STICK_CENTER - w_x;
			mag_s_s1   <= (w_s >= SPEED_ZERO) ? w_s - SPEED_ZERO : SPEED_ZERO - w_s;
			neg_lin_s1 <= (w_y < STICK_CENTER) != (w_s < SPEED_ZERO);
			neg_ang_s1 <= (w_x > STICK_CENTER) != (w_s < SPEED_ZERO);
			neg_spd_s1 <= (w_s < SPEED_ZERO);
			auto_s1    <= (w_rst >= swl_q);
			ovr_s1     <= (w_ovr >= swl_q);
			rreq_s1    <= (w_rst < {16'd0, arm_lim_q}) && armed_nx && (link_nx == LS_VALID);
		end
		if (cmd.mul1) begin
			p_lin_s2   <= 64'(mag_y_s1) * 64'(mag_s_s1);
			p_ang_s2   <= 64'(mag_x_s1) * 64'(mag_s_s1);
			spd_n_s2   <= 45'(mag_s_s1[23:0]) * 45'(SCALE_MULT);
			spd_sat_s2 <= (mag_s_s1 >= SCALE_SAT_MAG);
		end
		if (cmd.mul2) begin
			m_lin_s3   <= 56'(p_lin_s2[39:0]) * 56'(gain_q);
			m_ang_s3   <= 56'(p_ang_s2[39:0]) * 56'(gain_q);
			big_lin_s3 <= |p_lin_s2[63:40];
			big_ang_s3 <= |p_ang_s2[63:40];
			spd_n_s3   <= spd_n_s2;
			spd_sat_s3 <= spd_sat_s2;
		end
		if (cmd.divld) begin
			sat_s4[LANE_LIN] <= (gain_q != '0) && (big_lin_s3 || (n_lin >= SAT_LIMIT));
			sat_s4[LANE_ANG] <= (gain_q != '0) && (big_ang_s3 || (n_ang >= SAT_LIMIT));
			sat_s4[LANE_SPD] <= spd_sat_s3;
		end
	end

	// times 32 of the q8.8 gain product
	assign n_lin = {m_lin_s3, 5'd0};
	assign n_ang = {m_ang_s3, 5'd0};

	assign div_in[LANE_LIN] = n_lin[DIV_W-1:0];
	assign div_in[LANE_ANG] = n_ang[DIV_W-1:0];
	assign div_in[LANE_SPD] = DIV_W'(spd_n_s3);

	rcpwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.divld),
		.step     (cmd.dstep),
		.dividend (div_in),
		.quotient (quo),
		.done     (div_done)
	);

	assign status.div_done = div_done;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			res_q.out_channel      <= in_ch_q;
			res_q.pulse_width      <= !ch_ok ? '0 : (upd ? diff : width_q[ch_idx]);
			res_q.width_updated    <= upd;
			res_q.link_state       <= link_q;
			res_q.linear_velocity  <= '0;
			res_q.angular_velocity <= '0;
			res_q.speed_scale      <= '0;
			res_q.auto_mode        <= 1'b0;
			res_q.override_on      <= 1'b0;
			res_q.reset_request    <= 1'b0;
		end else if (cmd.ev_out) begin
			res_q.out_channel      <= '0;
			res_q.pulse_width      <= '0;
			res_q.width_updated    <= 1'b0;
			res_q.link_state       <= link_q;
			res_q.linear_velocity  <= sat_result(sat_s4[LANE_LIN], neg_lin_s1, quo[LANE_LIN]);
			res_q.angular_velocity <= sat_result(sat_s4[LANE_ANG], neg_ang_s1, quo[LANE_ANG]);
			res_q.speed_scale      <= sat_result(sat_s4[LANE_SPD], neg_spd_s1, quo[LANE_SPD]);
			res_q.auto_mode        <= auto_s1;
			res_q.override_on      <= ovr_s1;
			res_q.reset_request    <= rreq_s1;
		end
	end

	assign res = res_q;

	a_link_started: assert property (@(posedge clk) disable iff (!arst_n)
		(link_q != LS_NOT_STARTED) |=> (link_q != LS_NOT_STARTED))
		else $error("link status fell back to not started");

	a_armed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |=> armed_q)
		else $error("reset arm cleared");

	a_cap_keeps_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> (link_q == $past(link_q)))
		else $error("capture changed link status");

endmodule

`default_nettype wire

// ===== src/rcpwm_ctrl.sv =====
// controller: sequences capture and evaluate items and owns the output valid
// depends on rcpwm_pkg
`default_nettype none

module rcpwm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic                 in_mode,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output rcpwm_pkg::cmd_t           cmd,
	input  wire rcpwm_pkg::status_t   status
);
	import rcpwm_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CAP   = 8'b0000_0010,
		ST_LINK  = 8'b0000_0100,
		ST_MUL1  = 8'b0000_1000,
		ST_MUL2  = 8'b0001_0000,
		ST_DIVLD = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_nx   = in_mode ? ST_LINK : ST_CAP;
				end
			end
			ST_CAP: begin
				if (out_free) begin
					cmd.cap  = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_LINK: begin
				cmd.link = 1'b1;
				state_nx = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_nx = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_nx = ST_DIVLD;
			end
			ST_DIVLD: begin
				cmd.divld = 1'b1;
				state_nx  = ST_DIV;
			end
			ST_DIV: begin
				cmd.dstep = 1'b1;
				if (status.div_done) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.ev_out = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.cap || cmd.ev_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.cap || cmd.ev_out) |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten while full");

	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && status.div_done) |=> (state_q == ST_OUT))
		else $error("divider finish not followed by output");

	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && in_mode) |=> cmd.link)
		else $error("evaluate item did not start the link step");

endmodule

`default_nettype wire

// ===== src/rc_pwm_receiver_decoder.sv =====
// top level of the ten-channel rc pwm receiver decoder
// depends on rcpwm_pkg, rcpwm_ctrl, rcpwm_datapath (which holds rcpwm_div)
//
// usage
//   s_* stream: one item per transfer. s_tuser is the mode: 0 a capture edge
//   (channel, pin level, timer stamp), 1 an evaluate request.
//   m_* stream: one result per item, in order.
//   cfg_*: register writes, always ready; write only while the block is idle.
// sequencing
//   capture: the result is loaded in the CAP state once the result
//   register is free; the next item is taken after that, back in idle.
//   evaluate: the item steps through the LINK, MUL1, MUL2, DIVLD, DIV and
//   OUT states; in DIV the divider runs its 12 radix-16 digit steps, three
//   lanes in parallel (linear, angular, speed scale), until it reports
//   done. The next item is taken only after the result is loaded.
// reset
//   arst_n clears all pulse widths, rising stamps, link status and reset arm,
//   and loads the register defaults. No clearing pass is needed.
// stalls
//   the result register holds a finished item while m_tready is low; the next
//   input is still taken, and only its own result waits for the register.
`default_nettype none

module rc_pwm_receiver_decoder #(
	parameter int CHANNELS = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// input item
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [3:0] channel, [4] level, [36:5] timestamp, zero padded
	input  wire logic [rcpwm_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] mode
	input  wire logic                             s_tuser,
	// result item
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [3:0] out_channel, [35:4] pulse_width, [36] width_updated,
	// [38:37] link_state, [70:39] linear_velocity, [102:71] angular_velocity,
	// [134:103] speed_scale, [135] auto_mode, [136] override_on,
	// [137] reset_request, zero padded
	output logic      [rcpwm_pkg::M_TDATA_W-1:0]  m_tdata,
	// register writes
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rcpwm_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [rcpwm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rcpwm_pkg::*;

	cmd_t    cmd;
	status_t status;
	res_t    res;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	rcpwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_mode  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	rcpwm_datapath #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_valid),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.in_channel (s_tdata[CHAN_W-1:0]),
		.in_level   (s_tdata[CHAN_W]),
		.in_stamp   (s_tdata[CHAN_W+STAMP_W:CHAN_W+1]),
		.res        (res)
	);

	// pack the result, last field (out_channel) in the low bits
	assign m_tdata = {{(M_TDATA_W-RES_W){1'b0}}, res};

endmodule

`default_nettype wire

// ===== sim/rc_pwm_receiver_decoder_tb.sv =====
// self-checking bench for rc_pwm_receiver_decoder: capture and evaluate transfers
// checked against an in-bench decoder model, across several register settings
// depends on rcpwm_pkg and the rc_pwm_receiver_decoder rtl

module rc_pwm_receiver_decoder_tb;
	import rcpwm_pkg::*;

	localparam int NCH             = 10;
	localparam int IDLE_PCT        = 23;   // chance per cycle that a side idles
	localparam int ITEMS_PER_PHASE = 105;
	localparam int TAIL_CYCLES     = 25;   // evaluate latency plus margin

	// one input item as the stream carries it
	typedef struct {
		logic        mode;
		logic [3:0]  channel;
		logic        level;
		logic [31:0] stamp;
	} rc_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rc_pwm_receiver_decoder #(.CHANNELS(NCH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	// decoder model state, mirrors the block's pulse widths and link tracking
	logic [31:0]       rise_mark [NCH];
	logic [31:0]       pulse_len [NCH];
	link_t             link_now;
	logic              arm_latch;
	// model copy of the registers
	logic [15:0]       gain_q88, min_width, max_width, arm_level;
	logic [31:0]       drop_limit, switch_on_at;
	logic [MASK_W-1:0] wide_mask;

	rc_item_t pending_items [$];     // stimulus waiting for the driver
	res_t     expected_results [$];  // decoded results waiting for the monitor
	rc_item_t on_bus;                // item currently offered on s_*
	bit       bus_busy = 1'b0;
	bit       calm = 1'b0;           // no idling on either side while set

	int       errors = 0;
	int       n_capture = 0, n_eval = 0, n_checked = 0, n_settings = 0, n_requests = 0;
	logic [3:0] link_seen = '0;
	res_t     seen_res, want_res;

	// ------------------------------------------------------------------
	// decoder model
	// ------------------------------------------------------------------

	function automatic logic [31:0] width_at(input int ch);
		return (ch < NCH) ? pulse_len[ch] : 32'd0;
	endfunction

	// signed Q16.16 from a magnitude and a sign, saturating
	function automatic logic [31:0] clamp_q16(input logic [127:0] mag, input logic neg);
		if (neg) begin
			return (mag >= 128'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
		end
		return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
	endfunction

	// a * gain * b * 32 / 15625, exact in 128 bits, truncated toward zero
	function automatic logic [31:0] scaled_velocity(input longint a, input longint b);
		logic [127:0] mag;
		mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		mag = mag * 128'(gain_q88) * 128'd32 / 128'd15625;
		return clamp_q16(mag, (a < 0) != (b < 0));
	endfunction

	function automatic logic stick_ok(input logic [31:0] w);
		return w > min_width && w < max_width;
	endfunction

	function automatic res_t decode_item(input rc_item_t it);
		res_t        r;
		logic [31:0] diff;
		logic [31:0] rw;
		longint      dy, dx, ds;
		r = '0;
		if (!it.mode) begin
			r.out_channel = it.channel;
			if (it.channel < NCH) begin
				if (it.level) begin
					rise_mark[it.channel] = it.stamp;
				end else begin
					diff = it.stamp - rise_mark[it.channel];
					// channels without a wide bit count on a 16-bit timer
					if (!(it.channel < MASK_W && wide_mask[it.channel])) begin
						diff = diff & 32'h0000_FFFF;
					end
					if (diff != 32'd0) begin
						pulse_len[it.channel] = diff;
						r.width_updated = 1'b1;
					end
				end
				r.pulse_width = pulse_len[it.channel];
			end
			r.link_state = link_now;
			return r;
		end
		// evaluate: step the link first, everything else uses the new status
		if (link_now == LS_NOT_STARTED) begin
			for (int i = 0; i < NCH; i++) begin
				if (pulse_len[i] != 32'd0) begin
					link_now = LS_NOT_VALID;
				end
			end
		end else if (width_at(CH_MONITOR) > drop_limit) begin
			link_now = LS_DISCONNECTED;
		end else if (stick_ok(width_at(CH_X)) && stick_ok(width_at(CH_Y)) &&
				stick_ok(width_at(CH_SPEED))) begin
			link_now = LS_VALID;
		end else begin
			link_now = LS_NOT_VALID;
		end
		dy = longint'(width_at(CH_Y)) - longint'(STICK_CENTER);
		dx = longint'(STICK_CENTER) - longint'(width_at(CH_X));
		ds = longint'(width_at(CH_SPEED)) - longint'(SPEED_ZERO);
		rw = width_at(CH_RESET);
		r.link_state       = link_now;
		r.linear_velocity  = scaled_velocity(dy, ds);
		r.angular_velocity = scaled_velocity(dx, ds);
		// speed scale is (w - 500) * 16384 / 125
		r.speed_scale      = clamp_q16(128'(ds < 0 ? -ds : ds) * 128'd16384 / 128'd125, ds < 0);
		r.auto_mode        = width_at(CH_SWITCH) >= switch_on_at;
		r.override_on      = width_at(CH_OVERRIDE) >= switch_on_at;
		if (rw > arm_level) begin
			arm_latch = 1'b1;
		end
		r.reset_request = rw < arm_level && arm_latch && link_now == LS_VALID;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic queue_capture(input int ch, input logic lvl, input logic [31:0] stamp);
		pending_items.push_back(rc_item_t'{1'b0, 4'(ch), lvl, stamp});
	endtask

	// rising edge then falling edge len ticks later, wrapping as the timer does
	task automatic queue_pulse(input int ch, input logic [31:0] start, input logic [31:0] len);
		queue_capture(ch, 1'b1, start);
		queue_capture(ch, 1'b0, start + len);
	endtask

	// channel and stamp are don't-care on an evaluate, so fill them with noise
	task automatic queue_eval();
		pending_items.push_back(rc_item_t'{1'b1, 4'($urandom()), 1'($urandom()), $urandom()});
	endtask

	function automatic logic [31:0] near_value(input logic [31:0] v);
		return v + $urandom_range(4) - 32'd2;
	endfunction

	// pulse width that lands around the thresholds of the channel's role
	function automatic logic [31:0] pick_width(input int ch);
		int sel;
		sel = $urandom_range(99);
		case (ch)
			CH_X, CH_Y, CH_SPEED: begin
				if (sel < 65 && max_width > min_width + 1) begin
					return $urandom_range(max_width - 1, min_width + 1);
				end else if (sel < 80) begin
					return near_value(min_width);
				end else if (sel < 90) begin
					return near_value(max_width);
				end
				return $urandom();
			end
			CH_RESET: begin
				if (sel < 40) begin
					return near_value(arm_level);
				end else if (sel < 70) begin
					return near_value(switch_on_at);
				end
				return $urandom_range(2000);
			end
			CH_OVERRIDE: begin
				return (sel < 50) ? near_value(switch_on_at) : $urandom_range(3000);
			end
			CH_MONITOR: begin
				return (sel < 30) ? near_value(drop_limit) : $urandom_range(3000);
			end
			default: begin
				return (sel < 80) ? $urandom_range(65535) : $urandom();
			end
		endcase
	endfunction

	// mostly whole frames of pulses followed by an evaluate, plus noise
	task automatic queue_random(input int n);
		int made;
		int roll;
		int ch;
		made = 0;
		while (made < n) begin
			roll = $urandom_range(99);
			if (roll < 55) begin
				repeat ($urandom_range(4, 1)) begin
					if ($urandom_range(3) != 0) begin
						case ($urandom_range(5))
							0: ch = CH_X;
							1: ch = CH_Y;
							2: ch = CH_SPEED;
							3: ch = CH_RESET;
							4: ch = CH_OVERRIDE;
							default: ch = CH_MONITOR;
						endcase
					end else begin
						ch = $urandom_range(NCH - 1);
					end
					queue_pulse(ch, $urandom(), pick_width(ch));
					made += 2;
				end
				queue_eval();
				made++;
			end else if (roll < 75) begin
				queue_eval();
				made++;
			end else if (roll < 92) begin
				// any item at all, out-of-range channels included
				pending_items.push_back(rc_item_t'{1'($urandom()), 4'($urandom()),
					1'($urandom()), $urandom()});
				made++;
			end else begin
				// lone edge, breaks up a pulse on a real channel
				queue_capture($urandom_range(NCH - 1), 1'($urandom()), $urandom());
				made++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// register writes, only while the block has nothing in flight
	// ------------------------------------------------------------------

	// called at a falling edge; leaves cfg_valid high for a following write
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
		cfg_addr  <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SPEED_GAIN:   gain_q88     = value[15:0];
			REG_VALID_MIN:    min_width    = value[15:0];
			REG_VALID_MAX:    max_width    = value[15:0];
			REG_DISCONNECT:   drop_limit   = value;
			REG_SWITCH_LIMIT: switch_on_at = value;
			REG_RESET_ARM:    arm_level    = value[15:0];
			REG_WIDE_MASK:    wide_mask    = value[MASK_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// setting 0 defaults, 1 all zero, 2 all ones, above that random with
	// junk in the unused upper bits of the 16-bit registers
	task automatic apply_setting(input int k);
		case (k)
			0: begin
				write_reg(REG_SPEED_GAIN, 32'(RST_SPEED_GAIN));
				write_reg(REG_VALID_MIN, 32'(RST_VALID_MIN));
				write_reg(REG_VALID_MAX, 32'(RST_VALID_MAX));
				write_reg(REG_DISCONNECT, RST_DISCONNECT);
				write_reg(REG_SWITCH_LIMIT, RST_SWITCH_LIMIT);
				write_reg(REG_RESET_ARM, 32'(RST_RESET_ARM));
				write_reg(REG_WIDE_MASK, 32'(RST_WIDE_MASK));
			end
			1: begin
				write_reg(REG_SPEED_GAIN, 32'd0);
				write_reg(REG_VALID_MIN, 32'd0);
				write_reg(REG_VALID_MAX, 32'd0);
				write_reg(REG_DISCONNECT, 32'd0);
				write_reg(REG_SWITCH_LIMIT, 32'd0);
				write_reg(REG_RESET_ARM, 32'd0);
				write_reg(REG_WIDE_MASK, 32'd0);
			end
			2: begin
				write_reg(REG_SPEED_GAIN, 32'hFFFF_FFFF);
				write_reg(REG_VALID_MIN, 32'hFFFF_FFFF);
				write_reg(REG_VALID_MAX, 32'hFFFF_FFFF);
				write_reg(REG_DISCONNECT, 32'hFFFF_FFFF);
				write_reg(REG_SWITCH_LIMIT, 32'hFFFF_FFFF);
				write_reg(REG_RESET_ARM, 32'hFFFF_FFFF);
				write_reg(REG_WIDE_MASK, 32'hFFFF_FFFF);
			end
			default: begin
				write_reg(REG_SPEED_GAIN, {16'($urandom()),
					(k == 4) ? 16'hFFFF : 16'($urandom_range(1023, 1))});
				write_reg(REG_VALID_MIN, {16'($urandom()), 16'($urandom_range(560, 400))});
				write_reg(REG_VALID_MAX, {16'($urandom()), 16'($urandom_range(1200, 900))});
				write_reg(REG_DISCONNECT, $urandom_range(40000, 1000));
				write_reg(REG_SWITCH_LIMIT, $urandom_range(30000, 5000));
				write_reg(REG_RESET_ARM, {16'($urandom()), 16'($urandom_range(650, 450))});
				write_reg(REG_WIDE_MASK, $urandom());
			end
		endcase
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// nothing queued, nothing offered, no result outstanding
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || bus_busy || expected_results.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// input driver: offers the head of pending_items at a falling edge,
	// holds it until the transfer, idles at random in between
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n && !bus_busy) begin
			if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				on_bus = pending_items.pop_front();
				s_tdata  <= S_TDATA_W'({on_bus.stamp, on_bus.level, on_bus.channel});
				s_tuser  <= on_bus.mode;
				s_tvalid <= 1'b1;
				bus_busy = 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// input transfer: the model decodes the item now, in acceptance order
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_results.push_back(decode_item(on_bus));
			if (on_bus.mode) begin
				n_eval++;
			end else begin
				n_capture++;
			end
			bus_busy = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// result monitor: random backpressure, each transfer against the
	// oldest decoded result
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_res = res_t'(m_tdata[RES_W-1:0]);
			if (expected_results.size() == 0) begin
				$error("result transfer with no item outstanding: %h", m_tdata);
				errors++;
			end else begin
				want_res = expected_results.pop_front();
				n_checked++;
				link_seen[want_res.link_state] = 1'b1;
				n_requests += want_res.reset_request;
				check_field("out_channel", 32'(want_res.out_channel), 32'(seen_res.out_channel));
				check_field("pulse_width", want_res.pulse_width, seen_res.pulse_width);
				check_field("width_updated", 32'(want_res.width_updated),
					32'(seen_res.width_updated));
				check_field("link_state", 32'(want_res.link_state), 32'(seen_res.link_state));
				check_field("linear_velocity", want_res.linear_velocity,
					seen_res.linear_velocity);
				check_field("angular_velocity", want_res.angular_velocity,
					seen_res.angular_velocity);
				check_field("speed_scale", want_res.speed_scale, seen_res.speed_scale);
				check_field("auto_mode", 32'(want_res.auto_mode), 32'(seen_res.auto_mode));
				check_field("override_on", 32'(want_res.override_on),
					32'(seen_res.override_on));
				check_field("reset_request", 32'(want_res.reset_request),
					32'(seen_res.reset_request));
			end
		end
	end

	// ------------------------------------------------------------------
	// run limit, far beyond the slowest legal run
	// ------------------------------------------------------------------

	initial begin
		#10_000_000;
		$display("rc_pwm_receiver_decoder_tb: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------

	initial begin
		// model state as it comes out of reset
		for (int i = 0; i < NCH; i++) begin
			rise_mark[i] = 32'd0;
			pulse_len[i] = 32'd0;
		end
		link_now     = LS_NOT_STARTED;
		arm_latch    = 1'b0;
		gain_q88     = RST_SPEED_GAIN;
		min_width    = RST_VALID_MIN;
		max_width    = RST_VALID_MAX;
		drop_limit   = RST_DISCONNECT;
		switch_on_at = RST_SWITCH_LIMIT;
		arm_level    = RST_RESET_ARM;
		wide_mask    = RST_WIDE_MASK;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		apply_setting(0);

		// directed part, default registers
		queue_eval();                                 // nothing captured yet
		queue_capture(CH_X, 1'b1, 32'hFFFF_FFF0);
		queue_capture(CH_X, 1'b0, 32'h0000_02DE);     // falling edge after timer wrap
		queue_capture(CH_X, 1'b0, 32'hFFFF_FFF0);     // equal stamps keep the width
		queue_eval();                                 // leaves not started
		queue_capture(15, 1'b1, 32'h1234_5678);       // channels past the last one
		queue_capture(10, 1'b0, 32'hFFFF_FFFF);
		queue_pulse(5, 32'h0001_FFF0, 32'h0001_0030); // 16-bit counter drops the carry
		queue_pulse(CH_Y, 32'd0, 32'd800);
		queue_pulse(CH_SPEED, 32'd100, 32'd900);
		queue_eval();                                 // all sticks in range
		queue_pulse(CH_RESET, 32'd5000, 32'd600);
		queue_eval();                                 // arms the reset
		queue_pulse(CH_RESET, 32'd0, 32'd500);
		queue_eval();                                 // fires the reset request
		queue_pulse(CH_OVERRIDE, 32'd7, 32'd25000);
		queue_pulse(CH_MONITOR, 32'd0, 32'd30000);
		queue_eval();                                 // disconnected, override on
		queue_pulse(CH_SPEED, 32'd0, 32'hFFFF_FFFF);
		queue_eval();                                 // saturating speed and velocity

		// random phases, one register setting each; phase 3 runs without idling
		for (int k = 1; k <= 6; k++) begin
			wait_drained();
			apply_setting(k);
			calm = (k == 3);
			queue_random(ITEMS_PER_PHASE);
		end

		wait_drained();
		calm = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d capture and %0d evaluate transfers, %0d results checked",
			n_capture, n_eval, n_checked);
		$display("%0d register settings, link states seen %b, %0d reset requests",
			n_settings, link_seen, n_requests);
		if (errors == 0) begin
			$display("rc_pwm_receiver_decoder_tb: done, clean");
		end else begin
			$display("rc_pwm_receiver_decoder_tb: done, errors");
		end
		$finish;
	end

endmodule
